// ===== src/mipp_pkg.sv =====
// Shared types and constants for the MQTT incoming packet parser.
`default_nettype none
package mipp_pkg;

  typedef enum logic [1:0] {
    STAT_WAIT = 2'd0,
    STAT_DONE = 2'd1,
    STAT_ERR  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_HDR     = 2'd0,
    KIND_TOPIC   = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_SUBACK  = 2'd3
  } kind_t;

  typedef enum logic [12:0] {
    ST_HDR     = 13'b0000000000001,
    ST_RLFIX   = 13'b0000000000010,
    ST_RLVAR   = 13'b0000000000100,
    ST_RLNONE  = 13'b0000000001000,
    ST_CONN1   = 13'b0000000010000,
    ST_CONN2   = 13'b0000000100000,
    ST_PID1    = 13'b0000001000000,
    ST_PID2    = 13'b0000010000000,
    ST_TLEN1   = 13'b0000100000000,
    ST_TLEN2   = 13'b0001000000000,
    ST_TOPIC   = 13'b0010000000000,
    ST_PAYLOAD = 13'b0100000000000,
    ST_SUBACK  = 13'b1000000000000
  } step_t;

  // fixed header bytes
  localparam logic [7:0] HDR_CONNACK  = 8'h20;
  localparam logic [7:0] HDR_PUBACK   = 8'h40;
  localparam logic [7:0] HDR_PUBREC   = 8'h50;
  localparam logic [7:0] HDR_PUBREL   = 8'h62;
  localparam logic [7:0] HDR_PUBCOMP  = 8'h70;
  localparam logic [7:0] HDR_SUBACK   = 8'h90;
  localparam logic [7:0] HDR_UNSUBACK = 8'hB0;
  localparam logic [7:0] HDR_PINGRESP = 8'hD0;
  localparam logic [3:0] TYPE_CONNACK = 4'h2;
  localparam logic [3:0] TYPE_PUBLISH = 4'h3;
  localparam logic [3:0] TYPE_SUBACK  = 4'h9;
  localparam logic [7:0] SUBACK_FAIL  = 8'h80;

  typedef struct packed {
    status_t     status;
    kind_t       item_kind;
    logic [7:0]  data_byte;
    logic [7:0]  packet_type;
    logic [15:0] packet_id;
    logic [27:0] remaining_length;
    logic [15:0] topic_length;
    logic        session_present;
    logic [2:0]  connack_code;
  } result_t;

endpackage
`default_nettype wire

// ===== src/mqtt_incoming_packet_parser_unit.sv =====
// Top level of the MQTT 3.1.1 incoming packet parser.
// Takes one received word per cycle while out_stall is low and returns one result
// word per received word, after it passes the input register and then the result
// register, with the parser state updated as the word moves between them.
// Throughput is one word per cycle while out_stall is low; when the result
// register is stalled the input register still takes one more word and then
// in_stall rises until the result is taken.
`default_nettype none
module mqtt_incoming_packet_parser_unit #(
  parameter int SUBACK_MAX_CODES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [1:0]       out_item_kind,
  output logic [7:0]       out_data_byte,
  output logic [7:0]       out_packet_type,
  output logic [15:0]      out_packet_id,
  output logic [27:0]      out_remaining_length,
  output logic [15:0]      out_topic_length,
  output logic             out_session_present,
  output logic [2:0]       out_connack_code
);
  import mipp_pkg::*;

  logic       byte_valid;
  logic [7:0] byte_data;
  logic       adv;
  logic       out_v_r, out_v_nxt;
  result_t    res;
  result_t    res_r;

  // advance when the result register is empty or being drained
  assign adv       = byte_valid & (~out_v_r | ~out_stall);
  assign out_v_nxt = adv | (out_v_r & out_stall);

  mipp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .take       (adv),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  mipp_parser #(
    .SUBACK_MAX_CODES (SUBACK_MAX_CODES)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (adv),
    .rx_byte (byte_data),
    .result  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid            = out_v_r;
  assign out_status           = res_r.status;
  assign out_item_kind        = res_r.item_kind;
  assign out_data_byte        = res_r.data_byte;
  assign out_packet_type      = res_r.packet_type;
  assign out_packet_id        = res_r.packet_id;
  assign out_remaining_length = res_r.remaining_length;
  assign out_topic_length     = res_r.topic_length;
  assign out_session_present  = res_r.session_present;
  assign out_connack_code     = res_r.connack_code;

endmodule
`default_nettype wire

// ===== src/mipp_in_stage.sv =====
// Input register stage: holds one received word until the parser takes it.
`default_nettype none
module mipp_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       take,
  output logic            byte_valid,
  output logic [7:0]      byte_data
);
  import mipp_pkg::*;

  logic       v_r, v_nxt;
  logic [7:0] b_r;
  logic       load;

  assign in_stall   = v_r & ~take;
  assign load       = in_valid & ~in_stall;
  assign v_nxt      = load | (v_r & ~take);
  assign byte_valid = v_r;
  assign byte_data  = b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b_r <= in_rx_byte;
    end
  end

endmodule
`default_nettype wire

// ===== src/mipp_parser.sv =====
// Parser state and the per-byte next-state and result logic.
`default_nettype none
module mipp_parser #(
  parameter int SUBACK_MAX_CODES = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire logic [7:0] rx_byte,
  output mipp_pkg::result_t result
);
  import mipp_pkg::*;

  localparam logic [27:0] SubackMax = 28'(SUBACK_MAX_CODES);

  step_t       step_r, step_nxt;
  logic [7:0]  hdr_r, hdr_nxt;
  logic [2:0]  lbc_r, lbc_nxt;
  logic [27:0] dlen_r, dlen_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] ts_r, ts_nxt;
  logic [27:0] pos_r, pos_nxt;
  logic [27:0] ptot_r, ptot_nxt;
  logic        sess_r, sess_nxt;
  logic [2:0]  rc_r, rc_nxt;

  status_t     st;
  kind_t       kind;
  logic [1:0]  k;
  logic [27:0] len_part;
  logic [27:0] dlen_or;
  logic [27:0] pos_inc;
  logic [15:0] id_or;
  logic [15:0] ts_or;
  logic [17:0] need;
  logic        qos;

  assign qos     = (hdr_r[2:1] != 2'b00);
  assign k       = lbc_r[1:0];
  assign pos_inc = pos_r + 28'd1;
  assign id_or   = id_r | {8'h00, rx_byte};
  assign ts_or   = ts_r | {8'h00, rx_byte};
  assign need    = 18'd2 + {2'b00, ts_or} + (qos ? 18'd2 : 18'd0);
  assign dlen_or = dlen_r | len_part;

  always_comb begin
    case (k)
      2'd0:    len_part = {21'b0, rx_byte[6:0]};
      2'd1:    len_part = {14'b0, rx_byte[6:0], 7'b0};
      2'd2:    len_part = {7'b0, rx_byte[6:0], 14'b0};
      default: len_part = {rx_byte[6:0], 21'b0};
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    hdr_nxt  = hdr_r;
    lbc_nxt  = lbc_r;
    dlen_nxt = dlen_r;
    id_nxt   = id_r;
    ts_nxt   = ts_r;
    pos_nxt  = pos_r;
    ptot_nxt = ptot_r;
    sess_nxt = sess_r;
    rc_nxt   = rc_r;
    st       = STAT_WAIT;
    kind     = KIND_HDR;
    case (step_r)
      ST_RLFIX: begin
        dlen_nxt = {20'b0, rx_byte};
        if (rx_byte != 8'd2) begin
          st       = STAT_ERR;
          step_nxt = ST_HDR;
        end else begin
          step_nxt = (hdr_r[7:4] == TYPE_CONNACK) ? ST_CONN1 : ST_PID1;
        end
      end
      ST_RLVAR: begin
        dlen_nxt = dlen_or;
        if (rx_byte[7]) begin
          lbc_nxt = {1'b0, k} + 3'd1;
          if (k == 2'd3) begin
            st       = STAT_ERR;
            step_nxt = ST_HDR;
          end
        end else if (hdr_r[7:4] == TYPE_PUBLISH) begin
          step_nxt = ST_TLEN1;
        end else if (dlen_or > 28'd2 && (dlen_or - 28'd2) < SubackMax) begin
          ptot_nxt = dlen_or - 28'd2;
          pos_nxt  = '0;
          step_nxt = ST_PID1;
        end else begin
          st       = STAT_ERR;
          step_nxt = ST_HDR;
        end
      end
      ST_RLNONE: begin
        dlen_nxt = {20'b0, rx_byte};
        st       = (rx_byte == 8'd0) ? STAT_DONE : STAT_ERR;
        step_nxt = ST_HDR;
      end
      ST_CONN1: begin
        if (rx_byte < 8'd2) begin
          sess_nxt = rx_byte[0];
          step_nxt = ST_CONN2;
        end else begin
          st       = STAT_ERR;
          step_nxt = ST_HDR;
        end
      end
      ST_CONN2: begin
        if (rx_byte <= 8'd5) begin
          rc_nxt = rx_byte[2:0];
          st     = STAT_DONE;
        end else begin
          st = STAT_ERR;
        end
        step_nxt = ST_HDR;
      end
      ST_PID1: begin
        id_nxt   = {rx_byte, 8'h00};
        step_nxt = ST_PID2;
      end
      ST_PID2: begin
        id_nxt = id_or;
        if (id_or == 16'd0) begin
          st       = STAT_ERR;
          step_nxt = ST_HDR;
        end else begin
          pos_nxt = '0;
          if (hdr_r[7:4] == TYPE_SUBACK) begin
            step_nxt = ST_SUBACK;
          end else if (hdr_r[7:4] == TYPE_PUBLISH) begin
            ptot_nxt = ptot_r - 28'd2;
            if (ptot_r == 28'd2) begin
              st       = STAT_DONE;
              step_nxt = ST_HDR;
            end else begin
              step_nxt = ST_PAYLOAD;
            end
          end else begin
            st       = STAT_DONE;
            step_nxt = ST_HDR;
          end
        end
      end
      ST_TLEN1: begin
        ts_nxt   = {rx_byte, 8'h00};
        step_nxt = ST_TLEN2;
      end
      ST_TLEN2: begin
        ts_nxt = ts_or;
        if ({10'b0, need} > dlen_r) begin
          st       = STAT_ERR;
          step_nxt = ST_HDR;
        end else begin
          ptot_nxt = dlen_r - 28'd2 - {12'b0, ts_or};
          pos_nxt  = '0;
          if (ts_or != 16'd0) begin
            step_nxt = ST_TOPIC;
          end else if (qos) begin
            step_nxt = ST_PID1;
          end else if (dlen_r - 28'd2 == 28'd0) begin
            st       = STAT_DONE;
            step_nxt = ST_HDR;
          end else begin
            step_nxt = ST_PAYLOAD;
          end
        end
      end
      ST_TOPIC: begin
        kind    = KIND_TOPIC;
        pos_nxt = pos_inc;
        if (pos_inc >= {12'b0, ts_r}) begin
          // topic finished: packet id next, else payload or done
          pos_nxt = '0;
          if (qos) begin
            step_nxt = ST_PID1;
          end else if (ptot_r == 28'd0) begin
            st       = STAT_DONE;
            step_nxt = ST_HDR;
          end else begin
            step_nxt = ST_PAYLOAD;
          end
        end
      end
      ST_PAYLOAD: begin
        kind    = KIND_PAYLOAD;
        pos_nxt = pos_inc;
        if (pos_inc >= ptot_r) begin
          st       = STAT_DONE;
          step_nxt = ST_HDR;
        end
      end
      ST_SUBACK: begin
        kind = KIND_SUBACK;
        if (rx_byte < 8'd3 || rx_byte == SUBACK_FAIL) begin
          pos_nxt = pos_inc;
          if (pos_inc >= ptot_r) begin
            st       = STAT_DONE;
            step_nxt = ST_HDR;
          end
        end else begin
          st       = STAT_ERR;
          step_nxt = ST_HDR;
        end
      end
      default: begin
        // fixed header: clear per-packet state
        hdr_nxt  = rx_byte;
        lbc_nxt  = '0;
        dlen_nxt = '0;
        id_nxt   = '0;
        ts_nxt   = '0;
        pos_nxt  = '0;
        ptot_nxt = '0;
        sess_nxt = 1'b0;
        rc_nxt   = '0;
        if (rx_byte[7:4] == TYPE_PUBLISH) begin
          if (rx_byte[3:0] <= 4'h5 || rx_byte[3:0] >= 4'hA) begin
            step_nxt = ST_RLVAR;
          end else begin
            st       = STAT_ERR;
            step_nxt = ST_HDR;
          end
        end else begin
          case (rx_byte)
            HDR_CONNACK, HDR_PUBACK, HDR_PUBREC, HDR_PUBREL, HDR_PUBCOMP,
            HDR_UNSUBACK: step_nxt = ST_RLFIX;
            HDR_SUBACK:   step_nxt = ST_RLVAR;
            HDR_PINGRESP: step_nxt = ST_RLNONE;
            default: begin
              st       = STAT_ERR;
              step_nxt = ST_HDR;
            end
          endcase
        end
      end
    endcase
  end

  always_comb begin
    result.status           = st;
    result.item_kind        = kind;
    result.data_byte        = rx_byte;
    result.packet_type      = hdr_nxt;
    result.packet_id        = id_nxt;
    result.remaining_length = dlen_nxt;
    result.topic_length     = ts_nxt;
    result.session_present  = sess_nxt;
    result.connack_code     = rc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_HDR;
      hdr_r  <= '0;
      lbc_r  <= '0;
      dlen_r <= '0;
      id_r   <= '0;
      ts_r   <= '0;
      pos_r  <= '0;
      ptot_r <= '0;
      sess_r <= 1'b0;
      rc_r   <= '0;
    end else if (fire) begin
      step_r <= step_nxt;
      hdr_r  <= hdr_nxt;
      lbc_r  <= lbc_nxt;
      dlen_r <= dlen_nxt;
      id_r   <= id_nxt;
      ts_r   <= ts_nxt;
      pos_r  <= pos_nxt;
      ptot_r <= ptot_nxt;
      sess_r <= sess_nxt;
      rc_r   <= rc_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/mipp_checker.sv =====
// Port-level checks for the MQTT incoming packet parser, bound to the top level.
`default_nettype none
module mipp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  in_rx_byte,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_status,
  input wire logic [1:0]  out_item_kind,
  input wire logic [7:0]  out_data_byte,
  input wire logic [7:0]  out_packet_type,
  input wire logic [15:0] out_packet_id,
  input wire logic [27:0] out_remaining_length,
  input wire logic [15:0] out_topic_length,
  input wire logic        out_session_present,
  input wire logic [2:0]  out_connack_code
);
  import mipp_pkg::*;

  // hold a stalled input word
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_rx_byte))
    else $error("stalled input word changed");

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_data_byte) && $stable(out_packet_id) &&
      $stable(out_remaining_length) && $stable(out_topic_length))
    else $error("stalled result changed");

  // session flag and return code belong to CONNACK only
  a_connack_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_session_present || out_connack_code != 3'd0) |->
      out_packet_type == HDR_CONNACK && out_connack_code <= 3'd5)
    else $error("connack fields outside CONNACK");

  a_suback_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind == KIND_SUBACK |-> out_packet_type == HDR_SUBACK)
    else $error("return code word outside SUBACK");

  a_publish_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item_kind == KIND_TOPIC || out_item_kind == KIND_PAYLOAD) |->
      out_packet_type[7:4] == TYPE_PUBLISH && out_status != STAT_ERR)
    else $error("topic or payload word outside PUBLISH");

endmodule

bind mqtt_incoming_packet_parser_unit mipp_checker u_chk (.*);
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the MQTT incoming packet parser unit.
module testbench;
  import mipp_pkg::*;

  localparam int SUBACK_CODE_LIMIT = 32;
  localparam int CONNACK_CODE_MAX = 5;
  localparam int SUBACK_QOS_MAX = 2;
  localparam int FIXED_REM_LEN = 2;
  localparam int RANDOM_WORDS = 1200;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [7:0] LEN_MORE = 8'h80;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [1:0]  out_item_kind;
  logic [7:0]  out_data_byte;
  logic [7:0]  out_packet_type;
  logic [15:0] out_packet_id;
  logic [27:0] out_remaining_length;
  logic [15:0] out_topic_length;
  logic        out_session_present;
  logic [2:0]  out_connack_code;

  class parse_scoreboard;
    step_t       step;
    logic [7:0]  header;
    int unsigned len_bytes;
    int unsigned rem_len;
    int unsigned pos;
    int unsigned payload_len;
    logic [15:0] pid;
    logic [15:0] topic_len;
    logic        session;
    logic [2:0]  ack_code;
    result_t     pending[$];
    int unsigned errors;

    function new();
      step = ST_HDR;
      header = '0;
      len_bytes = 0;
      rem_len = 0;
      pos = 0;
      payload_len = 0;
      pid = '0;
      topic_len = '0;
      session = 1'b0;
      ack_code = '0;
      errors = 0;
    endfunction

    function bit qos_set();
      return header[2:1] != 2'b00;
    endfunction

    function status_t end_topic();
      pos = 0;
      if (qos_set()) begin
        step = ST_PID1;
        return STAT_WAIT;
      end
      if (payload_len == 0) return STAT_DONE;
      step = ST_PAYLOAD;
      return STAT_WAIT;
    endfunction

    function status_t fixed_header(logic [7:0] b);
      status_t st;
      st = STAT_WAIT;
      header = b;
      len_bytes = 0;
      rem_len = 0;
      pid = '0;
      topic_len = '0;
      pos = 0;
      payload_len = 0;
      session = 1'b0;
      ack_code = '0;
      if (b[7:4] == TYPE_PUBLISH) begin
        if (b[3:0] <= 4'h5 || b[3:0] >= 4'hA) step = ST_RLVAR;
        else st = STAT_ERR;
      end else begin
        case (b)
          HDR_CONNACK, HDR_PUBACK, HDR_PUBREC, HDR_PUBREL, HDR_PUBCOMP,
          HDR_UNSUBACK: step = ST_RLFIX;
          HDR_SUBACK:   step = ST_RLVAR;
          HDR_PINGRESP: step = ST_RLNONE;
          default:      st = STAT_ERR;
        endcase
      end
      return st;
    endfunction

    function status_t length_byte(logic [7:0] b);
      int unsigned k;
      int unsigned part;
      k = len_bytes & 3;
      part = b[6:0];
      rem_len = (rem_len | (part << (7 * k))) & 32'h0FFF_FFFF;
      if (b[7]) begin
        len_bytes = k + 1;
        return (len_bytes == 4) ? STAT_ERR : STAT_WAIT;
      end
      if (header[7:4] == TYPE_PUBLISH) begin
        step = ST_TLEN1;
        return STAT_WAIT;
      end
      if (rem_len > FIXED_REM_LEN && rem_len - FIXED_REM_LEN < SUBACK_CODE_LIMIT) begin
        payload_len = rem_len - FIXED_REM_LEN;
        pos = 0;
        step = ST_PID1;
        return STAT_WAIT;
      end
      return STAT_ERR;
    endfunction

    function status_t pid_low(logic [7:0] b);
      pid = pid | {8'h00, b};
      if (pid == 0) return STAT_ERR;
      pos = 0;
      if (header[7:4] == TYPE_SUBACK) begin
        step = ST_SUBACK;
        return STAT_WAIT;
      end
      if (header[7:4] == TYPE_PUBLISH) begin
        payload_len -= 2;
        if (payload_len == 0) return STAT_DONE;
        step = ST_PAYLOAD;
        return STAT_WAIT;
      end
      return STAT_DONE;
    endfunction

    function status_t topic_len_low(logic [7:0] b);
      int unsigned need;
      topic_len = topic_len | {8'h00, b};
      need = 2 + topic_len + (qos_set() ? 2 : 0);
      if (need > rem_len) return STAT_ERR;
      payload_len = rem_len - 2 - topic_len;
      pos = 0;
      if (topic_len == 0) return end_topic();
      step = ST_TOPIC;
      return STAT_WAIT;
    endfunction

    // Advance the parse state by one received word and queue its result.
    function void note_word(logic [7:0] b);
      status_t st;
      kind_t   kind;
      result_t r;
      st = STAT_WAIT;
      kind = KIND_HDR;
      case (step)
        ST_RLFIX: begin
          rem_len = b;
          if (b != FIXED_REM_LEN) st = STAT_ERR;
          else if (header[7:4] == TYPE_CONNACK) step = ST_CONN1;
          else step = ST_PID1;
        end
        ST_RLVAR: st = length_byte(b);
        ST_RLNONE: begin
          rem_len = b;
          st = (b == 8'd0) ? STAT_DONE : STAT_ERR;
        end
        ST_CONN1: begin
          if (b < 8'd2) begin
            session = b[0];
            step = ST_CONN2;
          end else st = STAT_ERR;
        end
        ST_CONN2: begin
          if (b <= CONNACK_CODE_MAX) begin
            ack_code = b[2:0];
            st = STAT_DONE;
          end else st = STAT_ERR;
        end
        ST_PID1: begin
          pid = {b, 8'h00};
          step = ST_PID2;
        end
        ST_PID2: st = pid_low(b);
        ST_TLEN1: begin
          topic_len = {b, 8'h00};
          step = ST_TLEN2;
        end
        ST_TLEN2: st = topic_len_low(b);
        ST_TOPIC: begin
          kind = KIND_TOPIC;
          pos = (pos + 1) & 32'h0FFF_FFFF;
          if (pos >= topic_len) st = end_topic();
        end
        ST_PAYLOAD: begin
          kind = KIND_PAYLOAD;
          pos = (pos + 1) & 32'h0FFF_FFFF;
          if (pos >= payload_len) st = STAT_DONE;
        end
        ST_SUBACK: begin
          kind = KIND_SUBACK;
          if (b <= SUBACK_QOS_MAX || b == SUBACK_FAIL) begin
            pos = (pos + 1) & 32'h0FFF_FFFF;
            if (pos >= payload_len) st = STAT_DONE;
          end else st = STAT_ERR;
        end
        default: st = fixed_header(b);
      endcase
      // completion and error both drop back to waiting for a fixed header
      if (st != STAT_WAIT) step = ST_HDR;
      r.status = st;
      r.item_kind = kind;
      r.data_byte = b;
      r.packet_type = header;
      r.packet_id = pid;
      r.remaining_length = rem_len[27:0];
      r.topic_length = topic_len;
      r.session_present = session;
      r.connack_code = ack_code;
      pending.push_back(r);
    endfunction

    function void compare_field(string name, logic [27:0] want, logic [27:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t: %s expected %0h got %0h", $time, name, want, seen);
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result expected none got %h", $time, got);
        return;
      end
      want = pending.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("item_kind", want.item_kind, got.item_kind);
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("packet_type", want.packet_type, got.packet_type);
      compare_field("packet_id", want.packet_id, got.packet_id);
      compare_field("remaining_length", want.remaining_length, got.remaining_length);
      compare_field("topic_length", want.topic_length, got.topic_length);
      compare_field("session_present", want.session_present, got.session_present);
      compare_field("connack_code", want.connack_code, got.connack_code);
    endfunction
  endclass

  mqtt_incoming_packet_parser_unit #(
    .SUBACK_MAX_CODES(SUBACK_CODE_LIMIT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_item_kind(out_item_kind),
    .out_data_byte(out_data_byte),
    .out_packet_type(out_packet_type),
    .out_packet_id(out_packet_id),
    .out_remaining_length(out_remaining_length),
    .out_topic_length(out_topic_length),
    .out_session_present(out_session_present),
    .out_connack_code(out_connack_code)
  );

  parse_scoreboard sb;
  logic [7:0]      pkt[$];
  bit              src_gaps;
  bit              sink_gaps;
  bit              hold_off_req;
  int unsigned     words_sent;
  int unsigned     quiet_cycles;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall <= sink_gaps && ($urandom_range(99) < 23);
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_status, out_item_kind, out_data_byte, out_packet_type, out_packet_id,
             out_remaining_length, out_topic_length, out_session_present,
             out_connack_code};
      sb.check_word(got);
    end
  end

  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one word from a falling edge and return at the falling edge after it is taken.
  task automatic put_word(input logic [7:0] b);
    while (src_gaps && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(b);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_pkt();
    foreach (pkt[i]) put_word(pkt[i]);
  endtask

  // Push bytes that force the parser back to header wait, or run out the packet.
  task automatic resync();
    while (sb.step != ST_HDR) begin
      case (sb.step)
        ST_RLFIX, ST_PID1, ST_PID2: put_word(8'h00);
        ST_RLNONE: put_word(8'h01);
        ST_RLVAR, ST_CONN1, ST_CONN2, ST_TLEN1, ST_TLEN2: put_word(8'hFF);
        ST_SUBACK: put_word(8'h55);
        default: put_word(8'($urandom_range(255)));
      endcase
    end
  endtask

  task automatic push_length(input int unsigned value);
    int unsigned nb;
    int unsigned part;
    nb = 1;
    while (nb < 4 && (value >> (7 * nb)) != 0) nb++;
    // pad with redundant continuation words now and then
    if ($urandom_range(9) == 0) nb = $urandom_range(4, nb);
    for (int i = 0; i < nb; i++) begin
      part = (value >> (7 * i)) & 32'h7F;
      if (i < nb - 1) part |= LEN_MORE;
      pkt.push_back(part[7:0]);
    end
  endtask

  task automatic make_packet();
    int unsigned pick;
    int unsigned f;
    int unsigned n;
    int unsigned tlen;
    int unsigned plen;
    int unsigned rl;
    logic [15:0] id;
    logic [15:0] tfield;
    pkt.delete();
    pick = $urandom_range(99);
    id = ($urandom_range(19) == 0) ? 16'h0000 : 16'($urandom_range(1, 16'hFFFF));
    if (pick < 35) begin
      do f = $urandom_range(15); while (f > 5 && f < 10);
      if ($urandom_range(99) < 3) f = $urandom_range(9, 6);
      tlen = $urandom_range(12);
      plen = ($urandom_range(9) == 0) ? $urandom_range(300, 100) : $urandom_range(24);
      rl = 2 + tlen + ((f[2:1] != 0) ? 2 : 0) + plen;
      tfield = 16'(tlen);
      if ($urandom_range(19) == 0) tfield = 16'($urandom_range(16'hFFFF, rl));
      pkt.push_back({TYPE_PUBLISH, f[3:0]});
      push_length(rl);
      pkt.push_back(tfield[15:8]);
      pkt.push_back(tfield[7:0]);
      repeat (tlen) pkt.push_back(8'($urandom_range(255)));
      if (f[2:1] != 0) begin
        pkt.push_back(id[15:8]);
        pkt.push_back(id[7:0]);
      end
      repeat (plen) pkt.push_back(8'($urandom_range(255)));
    end else if (pick < 47) begin
      pkt.push_back(HDR_CONNACK);
      pkt.push_back(($urandom_range(19) == 0) ? 8'($urandom_range(255)) : 8'd2);
      pkt.push_back(($urandom_range(19) == 0) ? 8'($urandom_range(255, 2)) :
                    8'($urandom_range(1)));
      pkt.push_back(($urandom_range(19) == 0) ? 8'($urandom_range(255, 6)) :
                    8'($urandom_range(CONNACK_CODE_MAX)));
    end else if (pick < 65) begin
      case ($urandom_range(4))
        0: pkt.push_back(HDR_PUBACK);
        1: pkt.push_back(HDR_PUBREC);
        2: pkt.push_back(HDR_PUBREL);
        3: pkt.push_back(HDR_PUBCOMP);
        default: pkt.push_back(HDR_UNSUBACK);
      endcase
      pkt.push_back(($urandom_range(19) == 0) ? 8'($urandom_range(255)) : 8'd2);
      pkt.push_back(id[15:8]);
      pkt.push_back(id[7:0]);
    end else if (pick < 72) begin
      pkt.push_back(HDR_PINGRESP);
      pkt.push_back(($urandom_range(19) == 0) ? 8'($urandom_range(255, 1)) : 8'd0);
    end else begin
      n = $urandom_range(SUBACK_CODE_LIMIT - 1, 1);
      rl = 2 + n;
      if ($urandom_range(19) == 0)
        rl = $urandom_range(1) ? $urandom_range(2) : $urandom_range(200, SUBACK_CODE_LIMIT + 2);
      pkt.push_back(HDR_SUBACK);
      push_length(rl);
      pkt.push_back(id[15:8]);
      pkt.push_back(id[7:0]);
      repeat (n) begin
        case ($urandom_range(3))
          0: pkt.push_back(8'd0);
          1: pkt.push_back(8'd1);
          2: pkt.push_back(8'd2);
          default: pkt.push_back(SUBACK_FAIL);
        endcase
        if ($urandom_range(99) < 3) pkt[pkt.size() - 1] = 8'($urandom_range(127, 3));
      end
    end
  endtask

  task automatic random_traffic(input int unsigned count);
    int unsigned start;
    int unsigned pick;
    int unsigned cut;
    logic [7:0]  junk;
    start = words_sent;
    while (words_sent - start < count) begin
      make_packet();
      pick = $urandom_range(99);
      if (pick < 80) begin
        send_pkt();
      end else begin
        if (pick < 90) begin
          // truncated packet, maybe with a stray word in place of the rest
          cut = $urandom_range(pkt.size() - 1, 1);
          for (int i = 0; i < cut; i++) put_word(pkt[i]);
        end
        if (pick >= 90 || $urandom_range(1)) begin
          junk = 8'($urandom_range(255));
          // keep a stray length word from closing on a huge remaining length
          if (sb.step == ST_RLVAR) junk[7] = 1'b1;
          put_word(junk);
        end
      end
      resync();
    end
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    hold_off_req = 1'b0;
    words_sent = 0;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    pkt = '{HDR_CONNACK, 8'h02, 8'h01, 8'h05}; send_pkt();
    pkt = '{HDR_CONNACK, 8'h02, 8'h00, 8'h00}; send_pkt();
    pkt = '{HDR_CONNACK, 8'h02, 8'h02}; send_pkt();
    pkt = '{HDR_CONNACK, 8'h02, 8'h00, 8'h06}; send_pkt();
    pkt = '{HDR_PUBACK, 8'h02, 8'hFF, 8'hFF}; send_pkt();
    pkt = '{HDR_PUBREC, 8'h02, 8'h00, 8'h01}; send_pkt();
    pkt = '{HDR_PUBREL, 8'h02, 8'h12, 8'h34}; send_pkt();
    pkt = '{HDR_PUBCOMP, 8'h03}; send_pkt();
    pkt = '{HDR_UNSUBACK, 8'h02, 8'h00, 8'h00}; send_pkt();
    pkt = '{HDR_PINGRESP, 8'h00, HDR_PINGRESP, 8'h01}; send_pkt();
    pkt = '{HDR_SUBACK, 8'h06, 8'h7F, 8'hFF, 8'h00, 8'h01, 8'h02, SUBACK_FAIL}; send_pkt();
    pkt = '{HDR_SUBACK, 8'h03, 8'h00, 8'h01, 8'h03}; send_pkt();
    pkt = '{HDR_SUBACK, 8'h02, HDR_SUBACK, 8'h22}; send_pkt();
    pkt = '{HDR_SUBACK, 8'hFF, 8'hFF, 8'hFF, 8'h7F}; send_pkt();
    pkt = '{HDR_SUBACK, 8'h80, 8'h80, 8'h80, 8'h80}; send_pkt();
    pkt = '{{TYPE_PUBLISH, 4'h0}, 8'h05, 8'h00, 8'h02, 8'h61, 8'h62, 8'h63}; send_pkt();
    pkt = '{{TYPE_PUBLISH, 4'h0}, 8'h02, 8'h00, 8'h00}; send_pkt();
    pkt = '{{TYPE_PUBLISH, 4'h2}, 8'h06, 8'h00, 8'h02, 8'h61, 8'h62, 8'h00, 8'h07};
    send_pkt();
    pkt = '{{TYPE_PUBLISH, 4'hD}, 8'h05, 8'h00, 8'h00, 8'h12, 8'h34, 8'h5A}; send_pkt();
    pkt = '{{TYPE_PUBLISH, 4'h0}, 8'h82, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00}; send_pkt();
    pkt = '{{TYPE_PUBLISH, 4'h0}, 8'h03, 8'h00, 8'h02}; send_pkt();
    pkt = '{{TYPE_PUBLISH, 4'hF}, 8'h7F, 8'hFF, 8'hFF}; send_pkt();
    pkt = '{{TYPE_PUBLISH, 4'h2}, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00}; send_pkt();
    pkt = '{{TYPE_PUBLISH, 4'h6}, {TYPE_PUBLISH, 4'h9}, 8'h00, 8'hFF}; send_pkt();
    resync();

    random_traffic(450);
    // no gaps on either side, and one long receiver hold-off to back up the input
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    hold_off_req = 1'b1;
    random_traffic(450);
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    random_traffic(RANDOM_WORDS - 900);

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== mqtt_incoming_packet_parser_unit.f =====
src/mipp_pkg.sv
src/mipp_in_stage.sv
src/mipp_parser.sv
src/mqtt_incoming_packet_parser_unit.sv
src/mipp_checker.sv
tb/testbench.sv
